>>> rtl/core/rpes_pkg.sv
// ----------------------------------------------------------------------------
// rpes_pkg
// Shared types and constants of the RGB PWM event scheduler.
// ----------------------------------------------------------------------------
package rpes_pkg;

  localparam int CHANNELS_DEF = 12;
  localparam int POS_FIELDS   = 12;
  localparam int SECTOR_DEG   = 60;

  localparam logic [47:0] POS_RST   = 48'hFEDA_9876_5210;
  localparam logic [15:0] IDLE_RST  = 16'hE7E7;
  localparam logic [7:0]  FSCALE_RST = 8'd255;

  // floor(x/15) == (x*RECIP_15) >> 16 for x < 4681
  localparam logic [12:0] RECIP_15 = 13'd4370;

  typedef enum logic [1:0] {
    REG_POS    = 2'd0,
    REG_IDLE   = 2'd1,
    REG_FSCALE = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HUE,
    ST_DUTY,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic fetch;
    logic calc;
    logic wr_duty;
    logic scan_clr;
    logic scan_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic found;
  } status_t;

endpackage

>>> rtl/core/rpes_ctrl.sv
// ----------------------------------------------------------------------------
// rpes_ctrl
// Sequencer: fetch issue, color calculation, duty write and event table rebuild.
// ----------------------------------------------------------------------------
module rpes_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_func,
  input  rpes_pkg::status_t status,
  output rpes_pkg::cmd_t    cmd,
  output logic              busy
);

  rpes_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rpes_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      rpes_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (in_func) begin
            cmd.fetch = 1'b1;
          end else begin
            cmd.load_in = 1'b1;
            state_nxt   = rpes_pkg::ST_HUE;
          end
        end
      end
      rpes_pkg::ST_HUE: begin
        cmd.calc  = 1'b1;
        state_nxt = rpes_pkg::ST_DUTY;
      end
      rpes_pkg::ST_DUTY: begin
        cmd.wr_duty  = 1'b1;
        cmd.scan_clr = 1'b1;
        state_nxt    = rpes_pkg::ST_SCAN;
      end
      rpes_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_nxt = rpes_pkg::ST_EMIT;
        end
      end
      rpes_pkg::ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = status.found ? rpes_pkg::ST_SCAN : rpes_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = rpes_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/rpes_dp.sv
// ----------------------------------------------------------------------------
// rpes_dp
// Datapath: registers, hue math, duty store, event tables and playback.
// ----------------------------------------------------------------------------
module rpes_dp #(
  parameter int CHANNELS = rpes_pkg::CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rpes_pkg::cmd_t    cmd,
  output rpes_pkg::status_t status,
  input  logic [1:0]        in_button,
  input  logic [8:0]        in_hue,
  input  logic [7:0]        in_level,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              out_valid,
  output logic [15:0]       out_shift_pattern,
  output logic [7:0]        out_duration
);

  localparam int MAX_EV = CHANNELS + 1;
  localparam int EW     = $clog2(MAX_EV);
  localparam int NW     = $clog2(MAX_EV + 1);
  localparam int CW     = $clog2(CHANNELS);

  // configuration
  logic [47:0] pos_r;
  logic [15:0] idle_r;
  logic [7:0]  fs_r;
  logic        cfg_wr;
  rpes_pkg::reg_idx_t cfg_idx;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = rpes_pkg::reg_idx_t'(paddr[4:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= rpes_pkg::POS_RST;
      idle_r <= rpes_pkg::IDLE_RST;
      fs_r   <= rpes_pkg::FSCALE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        rpes_pkg::REG_POS:    pos_r  <= pwdata[47:0];
        rpes_pkg::REG_IDLE:   idle_r <= pwdata[15:0];
        rpes_pkg::REG_FSCALE: fs_r   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      rpes_pkg::REG_POS:    prdata = {16'd0, pos_r};
      rpes_pkg::REG_IDLE:   prdata = {48'd0, idle_r};
      rpes_pkg::REG_FSCALE: prdata = {56'd0, fs_r};
      default:              prdata = '0;
    endcase
  end

  // hue to duties
  logic [1:0]  btn_r;
  logic [8:0]  hue_r;
  logic [7:0]  lvl_r;
  logic [2:0]  sec_r, sec_c;
  logic [13:0] prod_r;
  logic [8:0]  h_red;
  logic [5:0]  off_c;
  logic [24:0] qprod;
  logic [7:0]  q;
  logic [7:0]  rgb [3];

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      btn_r <= in_button;
      hue_r <= in_hue;
      lvl_r <= in_level;
    end
    if (cmd.calc) begin
      sec_r  <= sec_c;
      prod_r <= 14'(lvl_r * off_c);
    end
  end

  always_comb begin
    h_red = (hue_r >= 9'd360) ? 9'(hue_r - 9'd360) : hue_r;
    if (h_red < 9'd60) begin
      sec_c = 3'd0; off_c = 6'(h_red);
    end else if (h_red < 9'd120) begin
      sec_c = 3'd1; off_c = 6'(9'd120 - h_red);
    end else if (h_red < 9'd180) begin
      sec_c = 3'd2; off_c = 6'(h_red - 9'd120);
    end else if (h_red < 9'd240) begin
      sec_c = 3'd3; off_c = 6'(9'd240 - h_red);
    end else if (h_red < 9'd300) begin
      sec_c = 3'd4; off_c = 6'(h_red - 9'd240);
    end else begin
      sec_c = 3'd5; off_c = 6'(9'd360 - h_red);
    end
  end

  assign qprod = 25'(prod_r[13:2] * rpes_pkg::RECIP_15);
  assign q     = qprod[23:16];

  always_comb begin
    case (sec_r)
      3'd0:    begin rgb[0] = lvl_r; rgb[1] = q;     rgb[2] = 8'd0;  end
      3'd1:    begin rgb[0] = q;     rgb[1] = lvl_r; rgb[2] = 8'd0;  end
      3'd2:    begin rgb[0] = 8'd0;  rgb[1] = lvl_r; rgb[2] = q;     end
      3'd3:    begin rgb[0] = 8'd0;  rgb[1] = q;     rgb[2] = lvl_r; end
      3'd4:    begin rgb[0] = q;     rgb[1] = 8'd0;  rgb[2] = lvl_r; end
      default: begin rgb[0] = lvl_r; rgb[1] = 8'd0;  rgb[2] = q;     end
    endcase
  end

  // duty store
  logic [7:0] duty_r [CHANNELS];
  logic [3:0] ch_base;

  assign ch_base = {2'b00, btn_r} + {1'b0, btn_r, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) duty_r[i] <= 8'd0;
    end else if (cmd.wr_duty) begin
      for (int i = 0; i < CHANNELS; i++) begin
        for (int k = 0; k < 3; k++) begin
          if (5'(ch_base) + 5'(k) == 5'(i)) duty_r[i] <= rgb[k];
        end
      end
    end
  end

  // rebuild scan: one channel per cycle, one pass per event
  logic [CW-1:0] chan_r;
  logic [3:0]    fld_r;
  logic [15:0]   mask_r;
  logic [7:0]    cur_r, nxt_r;
  logic          found_r;
  logic [EW-1:0] evt_r;
  logic [7:0]    d;
  logic [3:0]    bpos;
  logic [7:0]    end_t;

  assign d    = duty_r[chan_r];
  assign bpos = pos_r[{fld_r, 2'b00} +: 4];
  assign status.scan_last = (chan_r == CW'(CHANNELS - 1));
  assign status.found     = found_r;
  assign end_t = found_r ? nxt_r : fs_r;

  // event tables, two banks
  logic [15:0]   pat_r  [2][MAX_EV];
  logic [7:0]    tick_r [2][MAX_EV];
  logic          act_r, zero_r, pend_rdy_r;
  logic [NW-1:0] act_cnt_r, pend_cnt_r;
  logic [EW-1:0] play_r;

  always_ff @(posedge clk) begin
    if (cmd.scan_clr || cmd.emit) begin
      chan_r  <= '0;
      fld_r   <= '0;
      mask_r  <= '0;
      found_r <= 1'b0;
    end else if (cmd.scan_step) begin
      chan_r <= chan_r + 1'b1;
      fld_r  <= (fld_r == 4'(rpes_pkg::POS_FIELDS - 1)) ? 4'd0 : fld_r + 4'd1;
      if (d < fs_r) begin
        if (d <= cur_r) begin
          mask_r[bpos] <= 1'b1;
        end else if (!found_r || d < nxt_r) begin
          nxt_r   <= d;
          found_r <= 1'b1;
        end
      end
    end
    if (cmd.scan_clr) begin
      cur_r <= 8'd0;
      evt_r <= '0;
    end else if (cmd.emit) begin
      pat_r[~act_r][evt_r]  <= idle_r & ~mask_r;
      tick_r[~act_r][evt_r] <= end_t - cur_r;
      if (found_r) begin
        cur_r <= nxt_r;
        evt_r <= evt_r + 1'b1;
      end
    end
  end

  logic          swap;
  logic          bank_use;
  logic [NW-1:0] cnt_use;

  assign swap     = pend_rdy_r && (play_r == '0);
  assign bank_use = swap ? ~act_r : act_r;
  assign cnt_use  = swap ? pend_cnt_r : act_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r      <= 1'b0;
      zero_r     <= 1'b1;
      pend_rdy_r <= 1'b0;
      act_cnt_r  <= NW'(1);
      pend_cnt_r <= NW'(1);
      play_r     <= '0;
      out_valid  <= 1'b0;
    end else begin
      out_valid <= cmd.fetch;
      if (cmd.emit && !found_r) begin
        pend_cnt_r <= NW'(evt_r) + NW'(1);
        pend_rdy_r <= 1'b1;
      end else if (cmd.fetch) begin
        if (swap) begin
          act_r      <= ~act_r;
          act_cnt_r  <= pend_cnt_r;
          zero_r     <= 1'b0;
          pend_rdy_r <= 1'b0;
        end
        play_r <= (NW'(play_r) + NW'(1) == cnt_use) ? '0 : play_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      out_shift_pattern <= (zero_r && !swap) ? 16'd0 : pat_r[bank_use][play_r];
      out_duration      <= (zero_r && !swap) ? 8'd0  : tick_r[bank_use][play_r];
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && !found_r) |=> pend_rdy_r)
    else $error("pending table not marked ready");
  assert property (@(posedge clk) disable iff (!rst_n)
    NW'(play_r) < act_cnt_r)
    else $error("play index beyond active count");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fetch && swap) |=> (!pend_rdy_r && !zero_r))
    else $error("table swap incomplete");

endmodule

>>> rtl/core/rgb_pwm_event_scheduler_core.sv
// ----------------------------------------------------------------------------
// rgb_pwm_event_scheduler_core
// Software-PWM event scheduler for RGB buttons with sorted event tables.
// ----------------------------------------------------------------------------
// Fetch: result strobe the cycle after the transfer; one per cycle while not busy.
// Set color: busy through hue calc, duty write and the rebuild, one scan pass and
//   one emit per event; events = distinct nonzero duties below full scale plus one.
// Rate is set by the rebuild scan, one channel compare per cycle.
// Synchronous reset restores register defaults, zero duties, empty tables.
// No backpressure on results.
module rgb_pwm_event_scheduler_core #(
  parameter int CHANNELS = rpes_pkg::CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [1:0]  in_button,
  input  logic [8:0]  in_hue,
  input  logic [7:0]  in_level,
  output logic        out_valid,
  output logic [15:0] out_shift_pattern,
  output logic [7:0]  out_duration,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  rpes_pkg::cmd_t    cmd;
  rpes_pkg::status_t status;

  assign pready = 1'b1;

  rpes_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_func(in_func),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  rpes_dp #(.CHANNELS(CHANNELS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_button        (in_button),
    .in_hue           (in_hue),
    .in_level         (in_level),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .out_valid        (out_valid),
    .out_shift_pattern(out_shift_pattern),
    .out_duration     (out_duration)
  );

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_func))
    else $error("result strobe without fetch");
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func) |=> out_valid)
    else $error("fetch without result");
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_func) |=> busy)
    else $error("color set did not start rebuild");

endmodule

>>> tb/tb_rgb_pwm_event_scheduler_core.sv
// ----------------------------------------------------------------------------
// tb_rgb_pwm_event_scheduler_core
// Self-checking bench for the RGB PWM event scheduler core.
// Drives color and fetch commands in random bursts, across several register
// settings. A local model of the duty table, event sort and playback
// predicts every fetched event, which is checked field by field.
// ----------------------------------------------------------------------------
module tb_rgb_pwm_event_scheduler_core;

  localparam int NCH  = 12;
  localparam int NEVT = NCH + 1;
  localparam int WDOG_LIMIT = 5000;

  typedef struct {
    logic [15:0] pattern;
    logic [7:0]  ticks;
  } pwm_event_t;

  typedef struct {
    logic        func;
    logic [1:0]  button;
    logic [8:0]  hue;
    logic [7:0]  level;
    logic        known;
    logic [15:0] k_pattern;
    logic [7:0]  k_ticks;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_func = 1'b0;
  logic [1:0]  in_button = '0;
  logic [8:0]  in_hue = '0;
  logic [7:0]  in_level = '0;
  logic        out_valid;
  logic [15:0] out_shift_pattern;
  logic [7:0]  out_duration;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  rgb_pwm_event_scheduler_core u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_button(in_button), .in_hue(in_hue), .in_level(in_level),
    .out_valid(out_valid), .out_shift_pattern(out_shift_pattern),
    .out_duration(out_duration),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // scheduler model state
  logic [47:0] m_pos;
  logic [15:0] m_idle;
  logic [7:0]  m_fscale;
  logic [7:0]  m_duty [NCH];
  pwm_event_t  m_pend [NEVT];
  pwm_event_t  m_act [NEVT];
  int          m_pend_cnt, m_act_cnt, m_play;
  logic        m_pend_rdy;

  pwm_event_t  event_q [$];
  logic        known_q [$];
  pwm_event_t  known_val_q [$];

  logic        row_known = 1'b0;
  pwm_event_t  row_val;
  int          errors = 0, mism = 0, wdog = 0;
  int          n_fetch = 0, n_color = 0, n_cfg = 0;

  function automatic logic [7:0] hue_part(logic [7:0] v, int off);
    return 8'((int'(v) * off) / 60);
  endfunction

  function automatic void rebuild_events();
    int order [NCH];
    logic [7:0] at [NEVT];
    logic [15:0] pat;
    logic [7:0] d, last, fin;
    int i, j, n, c;
    pat = m_idle;
    for (i = 0; i < NCH; i++) begin
      c = i;
      j = i;
      while (j > 0 && m_duty[order[j-1]] > m_duty[c]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = c;
    end
    n = 0;
    at[0] = 0;
    m_pend[0].pattern = m_idle;
    for (i = 0; i < NCH; i++) begin
      d = m_duty[order[i]];
      if (d >= m_fscale) break;
      if (d > at[n] && n + 1 < NEVT) begin
        n++;
        at[n] = d;
      end
      pat[m_pos[4*(order[i] % 12) +: 4]] = 1'b0;
      m_pend[n].pattern = pat;
    end
    n++;
    last = 0;
    for (i = 0; i < n; i++) begin
      fin = (i + 1 == n) ? m_fscale : at[i+1];
      m_pend[i].ticks = fin - last;
      last = fin;
    end
    m_pend_cnt = n;
    m_pend_rdy = 1'b1;
  endfunction

  function automatic void apply_color(logic [1:0] b, logic [8:0] hin, logic [7:0] v);
    int h;
    logic [7:0] rgb [3];
    h = hin;
    if (h >= 360) h -= 360;
    if (h < 60) begin
      rgb[0] = v; rgb[1] = hue_part(v, h); rgb[2] = 0;
    end else if (h < 120) begin
      rgb[0] = hue_part(v, 120 - h); rgb[1] = v; rgb[2] = 0;
    end else if (h < 180) begin
      rgb[0] = 0; rgb[1] = v; rgb[2] = hue_part(v, h - 120);
    end else if (h < 240) begin
      rgb[0] = 0; rgb[1] = hue_part(v, 240 - h); rgb[2] = v;
    end else if (h < 300) begin
      rgb[0] = hue_part(v, h - 240); rgb[1] = 0; rgb[2] = v;
    end else begin
      rgb[0] = v; rgb[1] = 0; rgb[2] = hue_part(v, 360 - h);
    end
    for (int k = 0; k < 3; k++)
      if (3 * b + k < NCH) m_duty[3*b+k] = rgb[k];
    rebuild_events();
  endfunction

  function automatic pwm_event_t next_event();
    pwm_event_t e;
    if (m_pend_rdy && m_play == 0) begin
      m_act = m_pend;
      m_act_cnt = m_pend_cnt;
      m_pend_rdy = 1'b0;
    end
    if (m_act_cnt == 0 || m_act_cnt > NEVT) m_act_cnt = 1;
    if (m_play >= m_act_cnt) m_play = 0;
    e = m_act[m_play];
    m_play = (m_play + 1) % m_act_cnt;
    return e;
  endfunction

  function automatic void model_reset();
    m_pos = rpes_pkg::POS_RST;
    m_idle = rpes_pkg::IDLE_RST;
    m_fscale = rpes_pkg::FSCALE_RST;
    for (int i = 0; i < NCH; i++) m_duty[i] = 0;
    for (int i = 0; i < NEVT; i++) begin
      m_pend[i] = '{16'h0, 8'h0};
      m_act[i] = '{16'h0, 8'h0};
    end
    m_pend_cnt = 1;
    m_act_cnt = 1;
    m_play = 0;
    m_pend_rdy = 1'b0;
  endfunction

  // monitor: check results, then predict for the transfer at this edge
  always @(posedge clk) begin
    pwm_event_t exp_e, kv;
    logic kn;
    if (rst_n) begin
      if (out_valid) begin
        if (event_q.size() == 0) begin
          errors++;
          if (mism++ < 10) $display("unexpected result %h/%h", out_shift_pattern, out_duration);
        end else begin
          exp_e = event_q.pop_front();
          kn = known_q.pop_front();
          kv = known_val_q.pop_front();
          if (out_shift_pattern !== exp_e.pattern || out_duration !== exp_e.ticks ||
              (kn && (out_shift_pattern !== kv.pattern || out_duration !== kv.ticks))) begin
            errors++;
            if (mism++ < 10)
              $display("mismatch: exp pattern %h duration %0d, got %h %0d",
                       kn ? kv.pattern : exp_e.pattern, kn ? kv.ticks : exp_e.ticks,
                       out_shift_pattern, out_duration);
          end
        end
      end
      if (start && !busy) begin
        if (in_func) begin
          event_q.push_back(next_event());
          known_q.push_back(row_known);
          known_val_q.push_back(row_val);
          n_fetch++;
        end else begin
          apply_color(in_button, in_hue, in_level);
          n_color++;
        end
      end
      wdog = (out_valid || (start && !busy) || (psel && penable)) ? 0 : wdog + 1;
      if (wdog >= WDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WDOG_LIMIT);
        $display("** rgb_pwm_event_scheduler_core: FAILED **");
        $finish;
      end
    end
  end

  task automatic send(logic f, logic [1:0] b, logic [8:0] h, logic [7:0] l);
    start <= 1'b1;
    in_func <= f;
    in_button <= b;
    in_hue <= h;
    in_level <= l;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    pause(1);
    while (busy !== 1'b0 || event_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(rpes_pkg::reg_idx_t idx, logic [63:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 5'(8 * idx);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      rpes_pkg::REG_POS:    m_pos = val[47:0];
      rpes_pkg::REG_IDLE:   m_idle = val[15:0];
      rpes_pkg::REG_FSCALE: m_fscale = val[7:0];
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic random_items(int count);
    int burst, left;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 16);
      while (burst > 0 && left > 0) begin
        if ($urandom_range(0, 3) == 0)
          send(1'b0, 2'($urandom), ($urandom_range(0, 7) == 0) ? 9'($urandom_range(360, 511))
                                                               : 9'($urandom_range(0, 359)),
               8'($urandom));
        else
          send(1'b1, 2'($urandom), 9'($urandom), 8'($urandom));
        burst--;
        left--;
      end
      if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 8));
    end
    pause(1);
  endtask

  dir_row_t dir_rows [] = '{
    '{1'b1, 2'd0, 9'd0,   8'd0,   1'b1, 16'h0000, 8'd0},
    '{1'b1, 2'd3, 9'd511, 8'd255, 1'b1, 16'h0000, 8'd0},
    '{1'b0, 2'd0, 9'd0,   8'd255, 1'b0, 16'h0, 8'd0},
    '{1'b1, 2'd0, 9'd0,   8'd0,   1'b0, 16'h0, 8'd0},
    '{1'b0, 2'd1, 9'd60,  8'd200, 1'b0, 16'h0, 8'd0},
    '{1'b0, 2'd2, 9'd130, 8'd100, 1'b0, 16'h0, 8'd0},
    '{1'b0, 2'd3, 9'd200, 8'd77,  1'b0, 16'h0, 8'd0},
    '{1'b1, 2'd0, 9'd0,   8'd0,   1'b0, 16'h0, 8'd0},
    '{1'b1, 2'd0, 9'd0,   8'd0,   1'b0, 16'h0, 8'd0},
    '{1'b0, 2'd0, 9'd250, 8'd254, 1'b0, 16'h0, 8'd0},
    '{1'b0, 2'd1, 9'd359, 8'd1,   1'b0, 16'h0, 8'd0},
    '{1'b0, 2'd2, 9'd360, 8'd128, 1'b0, 16'h0, 8'd0},
    '{1'b0, 2'd3, 9'd511, 8'd255, 1'b0, 16'h0, 8'd0},
    '{1'b1, 2'd0, 9'd0,   8'd0,   1'b0, 16'h0, 8'd0},
    '{1'b1, 2'd0, 9'd0,   8'd0,   1'b0, 16'h0, 8'd0},
    '{1'b1, 2'd0, 9'd0,   8'd0,   1'b0, 16'h0, 8'd0},
    '{1'b0, 2'd1, 9'd300, 8'd0,   1'b0, 16'h0, 8'd0},
    '{1'b0, 2'd2, 9'd120, 8'd255, 1'b0, 16'h0, 8'd0},
    '{1'b0, 2'd0, 9'd240, 8'd60,  1'b0, 16'h0, 8'd0},
    '{1'b1, 2'd0, 9'd0,   8'd0,   1'b0, 16'h0, 8'd0},
    '{1'b1, 2'd0, 9'd0,   8'd0,   1'b0, 16'h0, 8'd0},
    '{1'b1, 2'd0, 9'd0,   8'd0,   1'b0, 16'h0, 8'd0},
    '{1'b1, 2'd0, 9'd0,   8'd0,   1'b0, 16'h0, 8'd0}
  };

  initial begin
    model_reset();
    row_val = '{16'h0, 8'h0};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row_known <= dir_rows[i].known;
      row_val <= '{dir_rows[i].k_pattern, dir_rows[i].k_ticks};
      send(dir_rows[i].func, dir_rows[i].button, dir_rows[i].hue, dir_rows[i].level);
      if (i % 5 == 4) pause(2);
    end
    pause(1);
    row_known <= 1'b0;
    drain();

    random_items(200);
    drain();

    // register extremes, then random settings
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          reg_write(rpes_pkg::REG_POS, 64'h0);
          reg_write(rpes_pkg::REG_IDLE, 64'hFFFF);
          reg_write(rpes_pkg::REG_FSCALE, 64'd1);
        end
        1: begin
          reg_write(rpes_pkg::REG_POS, 64'hFFFF_FFFF_FFFF);
          reg_write(rpes_pkg::REG_IDLE, 64'h0);
          reg_write(rpes_pkg::REG_FSCALE, 64'd0);
        end
        2: begin
          reg_write(rpes_pkg::REG_POS, 64'h0123_4567_89AB);
          reg_write(rpes_pkg::REG_IDLE, 64'hFFFF);
          reg_write(rpes_pkg::REG_FSCALE, 64'd255);
        end
        default: begin
          reg_write(rpes_pkg::REG_POS, {$urandom, $urandom});
          reg_write(rpes_pkg::REG_IDLE, 64'($urandom));
          reg_write(rpes_pkg::REG_FSCALE, 64'($urandom_range(1, 255)));
        end
      endcase
      random_items(150);
      drain();
    end

    pause(1);
    repeat (20) @(posedge clk);
    $display("covered %0d fetches and %0d color updates over %0d register writes",
             n_fetch, n_color, n_cfg);
    if (errors == 0)
      $display("** rgb_pwm_event_scheduler_core: PASSED **");
    else
      $display("** rgb_pwm_event_scheduler_core: FAILED **");
    $finish;
  end

endmodule

>>> files.f
rtl/core/rpes_pkg.sv
rtl/core/rpes_ctrl.sv
rtl/core/rpes_dp.sv
rtl/core/rgb_pwm_event_scheduler_core.sv
tb/tb_rgb_pwm_event_scheduler_core.sv
